// ----- rtl/core/lpr_pkg.sv -----
// Shared types, constants and colour helpers of the line pixel rasterizer.
`default_nettype none

package lpr_pkg;

	localparam int COORD_BITS = 13;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int OFS_BITS   = 26;
	localparam int SIZE_BITS  = 13;
	localparam int STRIDE_BITS = 15;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;
	localparam int REG_IDX_BITS  = 2;
	localparam int COLOR_BITS = 16;
	localparam int CHAN_BITS  = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [SIZE_BITS-1:0]         size_t;
	typedef logic [STRIDE_BITS-1:0]       stride_t;
	typedef logic [OFS_BITS-1:0]          ofs_t;
	typedef logic [COLOR_BITS-1:0]        color_t;
	typedef logic [CHAN_BITS-1:0]         chan_t;

	// Request opcodes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// Register indexes, byte address is four times the index
	localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_STRIDE = 2'd2;

	localparam size_t   WIDTH_RST  = 13'd800;
	localparam size_t   HEIGHT_RST = 13'd480;
	localparam stride_t STRIDE_RST = 15'd2400;

	// Rounded 5 to 8 bit expansion: 8v + floor((7v + 15) / 31)
	function automatic chan_t expand5(input logic [4:0] v);
		logic [7:0] r;
		logic [2:0] q;
		r = 8'({3'b000, v} * 8'd7) + 8'd15;
		q = '0;
		for (int t = 1; t < 8; t++) begin
			if (r >= 8'(31 * t)) q = q + 3'd1;
		end
		return {v, 3'b000} + {5'b00000, q};
	endfunction

	// Rounded 6 to 8 bit expansion: 4v + floor((3v + 31) / 63)
	function automatic chan_t expand6(input logic [5:0] v);
		logic [7:0] r;
		logic [1:0] q;
		r = 8'({2'b00, v} * 8'd3) + 8'd31;
		q = '0;
		for (int t = 1; t < 4; t++) begin
			if (r >= 8'(63 * t)) q = q + 2'd1;
		end
		return {v, 2'b00} + {6'b000000, q};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/line_pixel_rasterizer_core.sv -----
// Top level of the Bresenham line pixel rasterizer.
`default_nettype none

// Bresenham line rasterizer. A start request (action = 0) latches two signed
// endpoints and an RGB565 colour and produces no pixel. Each step request
// (action = 1) produces the next pixel of the active line, from the first
// endpoint to the second inclusive; the final pixel carries last and the
// core then falls idle. A step while idle is swallowed, a start while a line
// is active drops that line. Each pixel carries its coordinates, drawn (pixel
// inside screen_width x screen_height), the BGR888 byte offset
// y * row_stride_bytes + x * 3 (zero when not drawn, wraps at 26 bits) and
// the colour expanded to eight bits per channel with rounding.
// Throughput is one request per clock while no pixel is stalled: the pixel is
// formed from the line state in a single stage whose critical path is the one
// y * stride multiply plus the x * 3 add, and lands in the output register.
// The output register frees as its pixel is taken, so req_stall is only high
// while a pixel sits stalled. Configuration sits on an APB port (width at 0x0,
// height at 0x4, stride at 0x8) and must be written while the core is idle.
module line_pixel_rasterizer_core (
	input  wire                              clk,
	input  wire                              arst_n,
	// APB configuration port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [lpr_pkg::APB_ADDR_BITS-1:0] paddr,
	input  wire [lpr_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [lpr_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                             pready,
	// request channel
	input  wire                              req_valid,
	output logic                             req_stall,
	input  wire                              action,
	input  wire lpr_pkg::coord_t             x_start,
	input  wire lpr_pkg::coord_t             y_start,
	input  wire lpr_pkg::coord_t             x_end,
	input  wire lpr_pkg::coord_t             y_end,
	input  wire lpr_pkg::color_t             color_565,
	// pixel channel
	output logic                             pix_valid,
	input  wire                              pix_stall,
	output logic                             drawn,
	output lpr_pkg::coord_t                  pixel_x,
	output lpr_pkg::coord_t                  pixel_y,
	output lpr_pkg::ofs_t                    byte_offset,
	output lpr_pkg::chan_t                   red,
	output lpr_pkg::chan_t                   green,
	output lpr_pkg::chan_t                   blue,
	output logic                             last
);
	import lpr_pkg::*;

	localparam int PROD_BITS = COORD_BITS + STRIDE_BITS;

	// configuration registers
	size_t   screen_width_q;
	size_t   screen_height_q;
	stride_t row_stride_q;

	// line state
	coord_t  cur_x_q, cur_y_q, target_x_q, target_y_q;
	delta_t  delta_x_q, neg_delta_y_q;
	logic    step_x_neg_q, step_y_neg_q;
	err_t    err_q;
	color_t  line_color_q;
	logic    active_q;

	// output register
	logic    pix_valid_q;
	logic    drawn_q, last_q;
	coord_t  pixel_x_q, pixel_y_q;
	ofs_t    byte_offset_q;
	chan_t   red_q, green_q, blue_q;

	logic                    cfg_wr;
	logic [REG_IDX_BITS-1:0] reg_idx;
	logic                    req_fire, start_fire, step_fire, emit;

	logic                    on_screen, at_target;
	logic [PROD_BITS-1:0]    row_ofs, ofs_full;
	logic                    adv_x, adv_y;
	logic signed [ERR_BITS:0] e2, err_sum;
	delta_t                  sx0, sy0, sx1, sy1, dx, dy;

	// Configuration port: zero wait states, decode on the word index
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_BITS-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = APB_DATA_BITS'(screen_width_q);
			REG_HEIGHT: prdata = APB_DATA_BITS'(screen_height_q);
			REG_STRIDE: prdata = APB_DATA_BITS'(row_stride_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RST;
			screen_height_q <= HEIGHT_RST;
			row_stride_q    <= STRIDE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  screen_width_q  <= pwdata[SIZE_BITS-1:0];
				REG_HEIGHT: screen_height_q <= pwdata[SIZE_BITS-1:0];
				REG_STRIDE: row_stride_q    <= pwdata[STRIDE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// Hold requests only while a finished pixel is stalled at the output
	assign req_stall  = pix_valid_q && pix_stall;
	assign req_fire   = req_valid && !req_stall;
	assign start_fire = req_fire && (action == ACT_START);
	assign step_fire  = req_fire && (action == ACT_STEP);
	assign emit       = step_fire && active_q;

	// Line set-up from the endpoints
	assign sx0 = DELTA_BITS'(x_start);
	assign sy0 = DELTA_BITS'(y_start);
	assign sx1 = DELTA_BITS'(x_end);
	assign sy1 = DELTA_BITS'(y_end);
	assign dx  = sx1 - sx0;
	assign dy  = sy1 - sy0;

	// Pixel at the current position
	assign on_screen = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
		(SIZE_BITS'(cur_x_q) < screen_width_q) &&
		(SIZE_BITS'(cur_y_q) < screen_height_q);
	assign at_target = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	assign row_ofs   = PROD_BITS'(unsigned'(cur_y_q)) * PROD_BITS'(row_stride_q);
	assign ofs_full  = row_ofs + PROD_BITS'(unsigned'(cur_x_q))
		+ PROD_BITS'({unsigned'(cur_x_q), 1'b0});

	// Error step: advance x when 2e >= -|dy|, advance y when 2e <= |dx|
	assign e2    = {err_q[ERR_BITS-1], err_q} <<< 1;
	assign adv_x = e2 >= (ERR_BITS+1)'(neg_delta_y_q);
	assign adv_y = e2 <= (ERR_BITS+1)'(delta_x_q);
	assign err_sum = (ERR_BITS+1)'(err_q)
		+ (adv_x ? (ERR_BITS+1)'(neg_delta_y_q) : '0)
		+ (adv_y ? (ERR_BITS+1)'(delta_x_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			delta_x_q     <= '0;
			neg_delta_y_q <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			err_q         <= '0;
			line_color_q  <= '0;
			active_q      <= 1'b0;
		end else if (start_fire) begin
			// drop any line in flight and load the new one
			cur_x_q       <= x_start;
			cur_y_q       <= y_start;
			target_x_q    <= x_end;
			target_y_q    <= y_end;
			delta_x_q     <= dx[DELTA_BITS-1] ? -dx : dx;
			neg_delta_y_q <= dy[DELTA_BITS-1] ? dy : -dy;
			step_x_neg_q  <= !(x_start < x_end);
			step_y_neg_q  <= !(y_start < y_end);
			err_q         <= ERR_BITS'(dx[DELTA_BITS-1] ? -dx : dx)
				+ ERR_BITS'(dy[DELTA_BITS-1] ? dy : -dy);
			line_color_q  <= color_565;
			active_q      <= 1'b1;
		end else if (emit) begin
			if (at_target) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_sum[ERR_BITS-1:0];
				if (adv_x) cur_x_q <= step_x_neg_q ? cur_x_q - COORD_BITS'(1)
					: cur_x_q + COORD_BITS'(1);
				if (adv_y) cur_y_q <= step_y_neg_q ? cur_y_q - COORD_BITS'(1)
					: cur_y_q + COORD_BITS'(1);
			end
		end
	end

	// Output register: load on emit, clear once the pixel is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (emit) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			drawn_q       <= on_screen;
			pixel_x_q     <= cur_x_q;
			pixel_y_q     <= cur_y_q;
			byte_offset_q <= on_screen ? ofs_full[OFS_BITS-1:0] : '0;
			red_q         <= expand5(line_color_q[15:11]);
			green_q       <= expand6(line_color_q[10:5]);
			blue_q        <= expand5(line_color_q[4:0]);
			last_q        <= at_target;
		end
	end

	assign pix_valid   = pix_valid_q;
	assign drawn       = drawn_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign byte_offset = byte_offset_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign last        = last_q;

	// A start always leaves a line active
	a_start_activates: assert property (@(posedge clk) disable iff (!arst_n)
		start_fire |=> active_q)
		else $error("start request did not activate a line");

	// The final pixel of a line returns the core to idle
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		emit && at_target |=> !active_q && pix_valid && last)
		else $error("final pixel did not end the line");

	// An off-screen pixel carries a zero offset
	a_offscreen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !drawn |-> byte_offset == '0)
		else $error("off-screen pixel with non-zero offset");

	// Requests are held back only behind a stalled pixel
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> pix_valid && pix_stall)
		else $error("request stalled with a free output register");

	// No pixel appears without an emitting step or a stalled pixel before it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!emit && !(pix_valid && pix_stall) |=> !pix_valid)
		else $error("pixel produced without a step on an active line");

endmodule

`default_nettype wire

// ----- sim/tb_line_pixel_rasterizer_core.sv -----
// Self-checking testbench of the line pixel rasterizer core: Bresenham pixels, clipping and colour.

module tb_line_pixel_rasterizer_core;
	import lpr_pkg::*;

	// Give up long after the slowest correct run could have ended.
	localparam int CYCLE_LIMIT = 400000;

	// One request as driven onto the request channel.
	typedef struct {
		logic   action;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
		color_t color;
	} line_req_t;

	// One pixel as it should leave the pixel channel.
	typedef struct {
		logic   drawn;
		coord_t x;
		coord_t y;
		ofs_t   ofs;
		chan_t  r;
		chan_t  g;
		chan_t  b;
		logic   last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	logic req_valid = 1'b0;
	logic req_stall;
	logic action = ACT_STEP;
	coord_t x_start = '0;
	coord_t y_start = '0;
	coord_t x_end = '0;
	coord_t y_end = '0;
	color_t color_565 = '0;

	logic pix_valid;
	logic pix_stall = 1'b0;
	logic drawn;
	coord_t pixel_x;
	coord_t pixel_y;
	ofs_t byte_offset;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic last;

	line_pixel_rasterizer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.color_565   (color_565),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.drawn       (drawn),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.byte_offset (byte_offset),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Idling percentages for the request sender and the pixel receiver.
	int send_gap_pct = 26;
	int pix_stall_pct = 53;

	int fail_count = 0;
	int cycle_count = 0;

	// Pixels predicted but not yet taken from the core, oldest first.
	pixel_t expected_pixels[$];
	pixel_t taken_pixel;

	// Shadow of the configuration registers.
	int cfg_width = WIDTH_RST;
	int cfg_height = HEIGHT_RST;
	int cfg_stride = STRIDE_RST;

	// Shadow of the line walker.
	int cur_x = 0;
	int cur_y = 0;
	int tgt_x = 0;
	int tgt_y = 0;
	int span_x = 0;
	int neg_span_y = 0;
	logic x_back = 1'b0;
	logic y_back = 1'b0;
	int err_acc = 0;
	color_t line_color = '0;
	logic line_active = 1'b0;

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Rounded widening of a colour channel to eight bits.
	function automatic chan_t widen_chan(input int v, input int maxv);
		return chan_t'((v * 255 + maxv / 2) / maxv);
	endfunction

	function automatic coord_t clamp_coord(input int v);
		if (v < -4096) return coord_t'(-4096);
		if (v > 4095) return coord_t'(4095);
		return coord_t'(v);
	endfunction

	function automatic line_req_t start_req(input int x0, input int y0, input int x1,
			input int y1, input color_t color);
		line_req_t r;
		r.action = ACT_START;
		r.xs = clamp_coord(x0);
		r.ys = clamp_coord(y0);
		r.xe = clamp_coord(x1);
		r.ye = clamp_coord(y1);
		r.color = color;
		return r;
	endfunction

	// A step request; the endpoint fields are ignored, so fill them with noise.
	function automatic line_req_t step_req();
		line_req_t r;
		r.action = ACT_STEP;
		r.xs = coord_t'($urandom);
		r.ys = coord_t'($urandom);
		r.xe = coord_t'($urandom);
		r.ye = coord_t'($urandom);
		r.color = color_t'($urandom);
		return r;
	endfunction

	// Advance the shadow line walker by one accepted request and queue the pixel of a step on an active line.
	task automatic rasterize(input line_req_t r);
		int dx;
		int dy;
		int e2;
		longint ofs;
		pixel_t p;
		if (r.action == ACT_START) begin
			cur_x = int'(r.xs);
			cur_y = int'(r.ys);
			tgt_x = int'(r.xe);
			tgt_y = int'(r.ye);
			dx = tgt_x - cur_x;
			dy = tgt_y - cur_y;
			span_x = (dx < 0) ? -dx : dx;
			neg_span_y = (dy < 0) ? dy : -dy;
			x_back = !(cur_x < tgt_x);
			y_back = !(cur_y < tgt_y);
			err_acc = span_x + neg_span_y;
			line_color = r.color;
			line_active = 1'b1;
		end else if (line_active) begin
			p.drawn = cur_x >= 0 && cur_y >= 0 && cur_x < cfg_width && cur_y < cfg_height;
			p.x = coord_t'(cur_x);
			p.y = coord_t'(cur_y);
			ofs = p.drawn ? (longint'(cur_y) * cfg_stride + longint'(cur_x) * 3) : 0;
			p.ofs = ofs_t'(ofs);
			p.r = widen_chan(int'(line_color[15:11]), 31);
			p.g = widen_chan(int'(line_color[10:5]), 63);
			p.b = widen_chan(int'(line_color[4:0]), 31);
			p.last = cur_x == tgt_x && cur_y == tgt_y;
			expected_pixels.push_back(p);
			if (p.last) begin
				line_active = 1'b0;
			end else begin
				e2 = 2 * err_acc;
				if (e2 >= neg_span_y) begin
					err_acc += neg_span_y;
					cur_x += x_back ? -1 : 1;
				end
				if (e2 <= span_x) begin
					err_acc += span_x;
					cur_y += y_back ? -1 : 1;
				end
			end
		end
	endtask

	// Offer one request, hold it until the core takes it, then predict.
	// Valid is left high so that back-to-back requests need no gap.
	task automatic send_request(input line_req_t r);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action <= r.action;
		x_start <= r.xs;
		y_start <= r.ys;
		x_end <= r.xe;
		y_end <= r.ye;
		color_565 <= r.color;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		rasterize(r);
	endtask

	// Drop valid, let every predicted pixel drain, then wait out the pipeline.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic check_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] exp_v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		check_field("prdata", exp_v, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register, update the shadow and read the value back.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
		int kept;
		kept = (idx == REG_STRIDE) ? (value & 32'h7FFF) : (value & 32'h1FFF);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WIDTH: cfg_width = kept;
			REG_HEIGHT: cfg_height = kept;
			default: cfg_stride = kept;
		endcase
		@(posedge clk);
		check_reg(idx, kept);
	endtask

	// Start a line and step it through to its last pixel.
	task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
			input color_t color);
		send_request(start_req(x0, y0, x1, y1, color));
		while (line_active) send_request(step_req());
	endtask

	// Take pixels as they come and compare each with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t unexpected pixel: expected none, got x %0d y %0d", $time,
					pixel_x, pixel_y);
				fail_count++;
			end else begin
				taken_pixel = expected_pixels.pop_front();
				check_field("drawn", taken_pixel.drawn, drawn);
				check_field("pixel_x", taken_pixel.x, pixel_x);
				check_field("pixel_y", taken_pixel.y, pixel_y);
				check_field("byte_offset", taken_pixel.ofs, byte_offset);
				check_field("red", taken_pixel.r, red);
				check_field("green", taken_pixel.g, green);
				check_field("blue", taken_pixel.b, blue);
				check_field("last", taken_pixel.last, last);
			end
		end
		pix_stall <= ($urandom_range(99) < pix_stall_pct);
	end

	// Registers must come out of reset at their documented values.
	task automatic test_register_defaults();
		check_reg(REG_WIDTH, WIDTH_RST);
		check_reg(REG_HEIGHT, HEIGHT_RST);
		check_reg(REG_STRIDE, STRIDE_RST);
	endtask

	// Steps with no line active must be swallowed.
	task automatic test_idle_step();
		send_request(step_req());
		send_request(step_req());
	endtask

	// Degenerate, shallow and steep lines, partly off screen, with pure colours.
	task automatic test_short_lines();
		draw_line(7, 9, 7, 9, 16'hFFFF);
		draw_line(3, 5, 5, 4, 16'hF800);
		draw_line(-2, -1, 0, 2, 16'h07E0);
	endtask

	// Extreme endpoints, then a start while active drops the first line.
	task automatic test_restart();
		send_request(start_req(-4096, -4096, 4095, 4095, 16'h001F));
		send_request(step_req());
		send_request(step_req());
		send_request(start_req(4095, -4096, -4096, 4095, 16'h0000));
		send_request(step_req());
		send_request(step_req());
	endtask

	// Walk off the bottom right corner of the screen, then step past the end.
	task automatic test_screen_edge();
		draw_line(799, 479, 800, 480, 16'hA5A5);
		send_request(step_req());
	endtask

	// Zero screen, a 4096 x 4096 screen with a wrapping offset, one-pixel screen.
	task automatic test_config_extremes();
		wait_idle();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 0);
		draw_line(0, 0, 1, 1, 16'h1234);
		wait_idle();
		write_reg(REG_WIDTH, 4096);
		write_reg(REG_HEIGHT, 4096);
		write_reg(REG_STRIDE, 32767);
		draw_line(4094, 4093, 4095, 4095, 16'h5A5A);
		wait_idle();
		write_reg(REG_WIDTH, 1);
		write_reg(REG_HEIGHT, 1);
		write_reg(REG_STRIDE, 3);
		draw_line(-1, -1, 1, 1, 16'hC3C3);
		wait_idle();
		write_reg(REG_WIDTH, WIDTH_RST);
		write_reg(REG_HEIGHT, HEIGHT_RST);
		write_reg(REG_STRIDE, STRIDE_RST);
	endtask

	// Mostly complete lines near the screen, with wild lines, cut lines and idle steps.
	task automatic run_random_phase(input int n_requests);
		int counted;
		int pick;
		int x0;
		int y0;
		int span;
		int cut;
		counted = 0;
		while (counted < n_requests) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// Endpoints anywhere in the coordinate range; take only a few pixels.
				send_request(start_req(int'(coord_t'($urandom)), int'(coord_t'($urandom)),
					int'(coord_t'($urandom)), int'(coord_t'($urandom)), color_t'($urandom)));
				cut = $urandom_range(1, 5);
			end else begin
				x0 = $urandom_range(0, cfg_width + 40) - 20;
				y0 = $urandom_range(0, cfg_height + 40) - 20;
				span = (pick < 20) ? 200 : 12;
				send_request(start_req(x0, y0, x0 + $urandom_range(0, 2 * span) - span,
					y0 + $urandom_range(0, 2 * span) - span, color_t'($urandom)));
				// Now and then abandon the line part way through.
				cut = (pick % 7 == 0) ? $urandom_range(0, 5) : 32'h4000_0000;
			end
			counted++;
			while (line_active && cut > 0) begin
				send_request(step_req());
				counted++;
				cut--;
			end
			if ($urandom_range(9) == 0) send_request(step_req());
		end
	endtask

	task automatic randomise_config();
		wait_idle();
		write_reg(REG_WIDTH, $urandom_range(1, 4096));
		write_reg(REG_HEIGHT, $urandom_range(1, 4096));
		write_reg(REG_STRIDE, $urandom_range(3, 16384));
	endtask

	// Three phases of random traffic, each with its own idling and screen setup.
	task automatic test_random_traffic();
		send_gap_pct = 26;
		pix_stall_pct = 53;
		run_random_phase(233);
		randomise_config();
		send_gap_pct = 53;
		pix_stall_pct = 26;
		run_random_phase(233);
		randomise_config();
		send_gap_pct = 0;
		pix_stall_pct = 0;
		run_random_phase(234);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_idle_step();
		test_short_lines();
		test_restart();
		test_screen_edge();
		test_config_extremes();
		test_random_traffic();
		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
